// ----- hdl/ppq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and constants of the paced priority queue: word layouts,
// stored entry layout, command and register codes, shared unit operations.
// ----------------------------------------------------------------------------
package ppq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    // command codes of an input word
    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_END  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic [1:0] CFG_OPEN   = 2'd0;
    localparam logic [1:0] CFG_FROZEN = 2'd1;
    localparam logic [1:0] CFG_GAP    = 2'd2;

    localparam logic [15:0] GAP_RESET = 16'd500;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,
        ALU_SUBZ = 2'd1,
        ALU_GT   = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now;
        logic [7:0]  priority_req;
        logic [31:0] max_wait;
        logic [31:0] duration;
        logic [15:0] sound_id;
        logic        sound_valid;
    } t_in_word;

    typedef struct packed {
        logic        play_valid;
        logic [15:0] play_id;
        logic [4:0]  expired_count;
        logic        enqueue_accepted;
        logic        queue_full;
        logic [4:0]  queue_level;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] tag;
        logic [31:0] enq_time;
        logic [31:0] wait_limit;
        logic [31:0] play_len;
    } t_entry;

    // entry store port control
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

// ----- hdl/ppq_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_alu
// Shared 34-bit adder: add, clamped subtract and greater-than compare.
// ----------------------------------------------------------------------------
module ppq_alu (
    input  ppq_pkg::t_alu_op i_op,
    input  logic [32:0]      i_a,
    input  logic [32:0]      i_b,
    output logic [32:0]      o_y
);

    logic [33:0] w_p;
    logic [33:0] w_q;
    logic [33:0] w_s;
    logic        w_sub;

    always_comb begin
        w_sub = (i_op != ppq_pkg::ALU_ADD);
        // greater-than is b - a, the borrow says a > b
        if (i_op == ppq_pkg::ALU_GT) begin
            w_p = {1'b0, i_b};
            w_q = {1'b0, i_a};
        end else begin
            w_p = {1'b0, i_a};
            w_q = {1'b0, i_b};
        end
        w_s = w_p + (w_sub ? ~w_q : w_q) + 34'(w_sub);
        unique case (i_op)
            ppq_pkg::ALU_ADD:  o_y = w_s[32:0];
            ppq_pkg::ALU_SUBZ: o_y = w_s[33] ? 33'd0 : w_s[32:0];
            ppq_pkg::ALU_GT:   o_y = {32'd0, w_s[33]};
            default:           o_y = 33'd0;
        endcase
    end

endmodule

// ----- hdl/ppq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_store
// Entry memory, one port: a write or a registered read per cycle.
// ----------------------------------------------------------------------------
module ppq_store #(
    parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH)
) (
    input  logic              i_clk,
    input  ppq_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  ppq_pkg::t_entry   i_wdata,
    output ppq_pkg::t_entry   o_rdata
);

    ppq_pkg::t_entry r_mem [QUEUE_DEPTH];
    ppq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

`ifndef SYNTH
    // the sequencer never reads and writes in one cycle
    a_one_access: assert property (@(posedge i_clk) !(i_ctl.wr && i_ctl.rd))
        else $error("store read and write in the same cycle");
`endif

endmodule

// ----- hdl/paced_priority_queue_with_expiry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paced_priority_queue_with_expiry
// Priority queue of sound requests with pacing between sounds and expiry of
// stale requests, run by a small sequencer around one shared adder.
// ----------------------------------------------------------------------------
// Holds up to QUEUE_DEPTH requests in a circular entry memory, kept sorted by
// descending priority, equal priorities first in, first out. Every input word
// gives exactly one result word. An enqueue walks from the tail toward the
// head, moving one entry per step of read, then compare and write back, until
// an entry of equal or higher priority or the head is reached, then writes
// the request into the hole. A tick first does the pacing check (add, then
// compare), then takes entries from the head with read, subtract and compare
// each, and plays the first live one; a sound-ended word, a rejected request
// or an idle tick goes straight to the result. The single-port entry memory
// and the shared 34-bit adder set this order of steps. The next word is
// accepted while a result still waits at the output register. Configuration
// writes apply at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module paced_priority_queue_with_expiry #(
    parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ppq_pkg::t_in_word i_in_data,
    // result side
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ppq_pkg::t_out_word o_out_data,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int LW    = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_PACE_ADD,
        S_PACE_CMP,
        S_POP_RD,
        S_POP_SUB,
        S_POP_CMP,
        S_POP_PLAY,
        S_FIN
    } t_state;

    // control state
    t_state              r_state,      n_state;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic [AW-1:0]       r_head,       n_head;
    logic [31:0]         r_nat,        n_nat;
    logic                r_open,       n_open;
    logic                r_frozen,     n_frozen;
    logic [15:0]         r_gap,        n_gap;
    logic                r_out_valid,  n_out_valid;
    // working registers of the current word
    ppq_pkg::t_in_word   r_in,         n_in;
    logic [CNT_W-1:0]    r_pos,        n_pos;
    logic [32:0]         r_acc,        n_acc;
    logic [CNT_W-1:0]    r_exp,        n_exp;
    logic                r_play_valid, n_play_valid;
    logic [15:0]         r_play_id,    n_play_id;
    logic                r_accepted,   n_accepted;
    logic                r_full,       n_full;
    ppq_pkg::t_out_word  r_out,        n_out;

    // shared unit and store hookup
    ppq_pkg::t_alu_op    w_alu_op;
    logic [32:0]         w_alu_a;
    logic [32:0]         w_alu_b;
    logic [32:0]         w_alu_y;
    ppq_pkg::t_mem_ctl   w_mem_ctl;
    ppq_pkg::t_entry     w_wdata;
    ppq_pkg::t_entry     w_rdata;
    ppq_pkg::t_entry     w_new;
    logic [CNT_W-1:0]    w_k;
    logic [SUM_W-1:0]    w_sum;
    logic [AW-1:0]       w_addr;
    logic [AW-1:0]       w_head_inc;
    logic [LW-1:0]       w_exp_ext;
    logic [LW-1:0]       w_lvl_ext;

    ppq_alu u_alu (
        .i_op (w_alu_op),
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .o_y  (w_alu_y)
    );

    ppq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // logical slot k to memory address, relative to the head
    always_comb begin
        w_sum = SUM_W'(r_head) + SUM_W'(w_k);
        if (w_sum >= SUM_W'(QUEUE_DEPTH)) begin
            w_sum = w_sum - SUM_W'(QUEUE_DEPTH);
        end
        w_addr = w_sum[AW-1:0];
    end

    assign w_head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // entry built from the held request
    always_comb begin
        w_new.prio       = r_in.priority_req;
        w_new.tag        = r_in.sound_id;
        w_new.enq_time   = r_in.now;
        w_new.wait_limit = r_in.max_wait;
        w_new.play_len   = r_in.duration;
    end

    assign w_exp_ext = LW'(r_exp);
    assign w_lvl_ext = LW'(r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_nat        = r_nat;
        n_open       = r_open;
        n_frozen     = r_frozen;
        n_gap        = r_gap;
        n_out_valid  = r_out_valid;
        n_in         = r_in;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_exp        = r_exp;
        n_play_valid = r_play_valid;
        n_play_id    = r_play_id;
        n_accepted   = r_accepted;
        n_full       = r_full;
        n_out        = r_out;
        w_alu_op     = ppq_pkg::ALU_ADD;
        w_alu_a      = '0;
        w_alu_b      = '0;
        w_mem_ctl    = '0;
        w_wdata      = w_rdata;
        w_k          = '0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // register writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppq_pkg::CFG_OPEN:   n_open   = i_cfg_data[0];
                ppq_pkg::CFG_FROZEN: n_frozen = i_cfg_data[0];
                ppq_pkg::CFG_GAP:    n_gap    = i_cfg_data;
                default:             ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in         = i_in_data;
                    n_exp        = '0;
                    n_play_valid = 1'b0;
                    n_play_id    = '0;
                    n_accepted   = 1'b0;
                    n_full       = 1'b0;
                    n_state      = S_FIN;
                    unique case (i_in_data.command)
                        ppq_pkg::CMD_ENQ: begin
                            if (r_open && i_in_data.sound_valid) begin
                                if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                    n_full = 1'b1;
                                end else begin
                                    // start the walk at the tail
                                    n_pos   = r_count;
                                    n_state = S_INS_RD;
                                end
                            end
                        end
                        ppq_pkg::CMD_TICK: begin
                            if (r_count != '0 && !r_frozen) begin
                                n_state = S_PACE_ADD;
                            end
                        end
                        ppq_pkg::CMD_END: begin
                            n_nat = i_in_data.now;
                        end
                        default: ;
                    endcase
                end
            end

            // insert: read the entry just ahead of the hole
            S_INS_RD: begin
                if (r_pos == '0) begin
                    n_state = S_INS_PUT;
                end else begin
                    w_mem_ctl.rd = 1'b1;
                    w_k          = r_pos - 1'b1;
                    n_state      = S_INS_CHK;
                end
            end

            // strictly lower priority moves back one slot, equal stays ahead
            S_INS_CHK: begin
                w_alu_op = ppq_pkg::ALU_GT;
                w_alu_a  = 33'(r_in.priority_req);
                w_alu_b  = 33'(w_rdata.prio);
                if (w_alu_y[0]) begin
                    w_mem_ctl.wr = 1'b1;
                    w_k          = r_pos;
                    w_wdata      = w_rdata;
                    n_pos        = r_pos - 1'b1;
                    n_state      = S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                w_mem_ctl.wr = 1'b1;
                w_k          = r_pos;
                w_wdata      = w_new;
                n_count      = r_count + 1'b1;
                n_accepted   = 1'b1;
                n_state      = S_FIN;
            end

            // pacing: earliest start, kept 33 bits wide
            S_PACE_ADD: begin
                w_alu_op = ppq_pkg::ALU_ADD;
                w_alu_a  = 33'(r_nat);
                w_alu_b  = 33'(r_gap);
                n_acc    = w_alu_y;
                n_state  = S_PACE_CMP;
            end

            S_PACE_CMP: begin
                w_alu_op = ppq_pkg::ALU_GT;
                w_alu_a  = r_acc;
                w_alu_b  = 33'(r_in.now);
                n_state  = w_alu_y[0] ? S_FIN : S_POP_RD;
            end

            S_POP_RD: begin
                w_mem_ctl.rd = 1'b1;
                w_k          = '0;
                n_state      = S_POP_SUB;
            end

            // elapsed wait, zero when now is before the enqueue time
            S_POP_SUB: begin
                w_alu_op = ppq_pkg::ALU_SUBZ;
                w_alu_a  = 33'(r_in.now);
                w_alu_b  = 33'(w_rdata.enq_time);
                n_acc    = w_alu_y;
                n_head   = w_head_inc;
                n_count  = r_count - 1'b1;
                n_state  = S_POP_CMP;
            end

            S_POP_CMP: begin
                w_alu_op = ppq_pkg::ALU_GT;
                w_alu_a  = r_acc;
                w_alu_b  = 33'(w_rdata.wait_limit);
                if (w_alu_y[0]) begin
                    n_exp   = r_exp + 1'b1;
                    n_state = (r_count == '0) ? S_FIN : S_POP_RD;
                end else begin
                    n_state = S_POP_PLAY;
                end
            end

            // live head plays, next start saturates at all ones
            S_POP_PLAY: begin
                w_alu_op     = ppq_pkg::ALU_ADD;
                w_alu_a      = 33'(r_in.now);
                w_alu_b      = 33'(w_rdata.play_len);
                n_nat        = w_alu_y[32] ? 32'hFFFF_FFFF : w_alu_y[31:0];
                n_play_valid = 1'b1;
                n_play_id    = w_rdata.tag;
                n_state      = S_FIN;
            end

            // hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.play_valid       = r_play_valid;
                    n_out.play_id          = r_play_id;
                    n_out.expired_count    = w_exp_ext[4:0];
                    n_out.enqueue_accepted = r_accepted;
                    n_out.queue_full       = r_full;
                    n_out.queue_level      = w_lvl_ext[4:0];
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_in         <= n_in;
        r_pos        <= n_pos;
        r_acc        <= n_acc;
        r_exp        <= n_exp;
        r_play_valid <= n_play_valid;
        r_play_id    <= n_play_id;
        r_accepted   <= n_accepted;
        r_full       <= n_full;
        r_out        <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_nat       <= '0;
            r_open      <= 1'b1;
            r_frozen    <= 1'b0;
            r_gap       <= ppq_pkg::GAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_nat       <= n_nat;
            r_open      <= n_open;
            r_frozen    <= n_frozen;
            r_gap       <= n_gap;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // fill level never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // the sequencer only leaves idle on an accepted word
    a_start_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) == S_IDLE) |-> $past(i_in_valid))
        else $error("sequencer started without an input word");

    // an enqueue result never reports both stored and full
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.enqueue_accepted && o_out_data.queue_full))
        else $error("enqueue both accepted and full");

    // no tag without a started sound
    a_idle_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.play_valid) |-> o_out_data.play_id == 16'd0)
        else $error("play tag without a started sound");

    // the head only moves while entries are taken on a tick
    a_head_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != $past(r_head)) |-> $past(r_state) == S_POP_SUB)
        else $error("head moved outside a pop");
`endif

endmodule
